### src/lav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and widths for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

   localparam int FIELD_W   = 32;  // port field width, Q16.16
   localparam int FRAC_W    = 16;  // fraction bits
   localparam int NV_W      = 52;  // normalizer input, signed
   localparam int MAG_W     = 51;  // normalizer magnitude
   localparam int TOP_W     = 6;   // index of leading one in a magnitude
   localparam int SCALE_TOP = 29;  // the largest scaled magnitude lies in [2^29, 2^30)
   localparam int SM_W      = 30;  // scaled magnitude
   localparam int SQ_W      = 60;  // square of a scaled magnitude
   localparam int SUM_W     = 62;  // sum of three squares
   localparam int RT_W      = 31;  // integer square root of the sum
   localparam int NUM_W     = 47;  // dividend of the unit scaling
   localparam int Q_W       = 17;  // unit quotient, at most 1.0
   localparam int UV_W      = 18;  // signed unit component
   localparam int CA_W      = 32;  // cross product left operand
   localparam int CB_W      = 19;  // cross product right operand
   localparam int CP_W      = 51;  // cross product partial product
   localparam int CX_W      = 52;  // cross product result
   localparam int NUP_W     = 19;  // orthogonal up component
   localparam int RGT_W     = 20;  // final right component
   localparam int DP_W      = 52;  // dot product partial product
   localparam int DS_W      = 54;  // dot product sum
   localparam int DR_W      = 38;  // rounded dot product
   localparam int DIFF_W    = 33;  // target minus eye

   // normalizer: 6 front stages, one per root bit, dividend prep,
   // one per quotient bit, sign stage
   localparam int NL  = 6 + RT_W + 1 + Q_W + 1;
   localparam int L1  = 1 + NL;      // look ready
   localparam int L2  = L1 + 2 + NL; // first right ready
   localparam int TOT = L2 + 7;      // output register

   typedef struct packed {
      logic signed [FIELD_W-1:0] eye_x;
      logic signed [FIELD_W-1:0] eye_y;
      logic signed [FIELD_W-1:0] eye_z;
      logic signed [FIELD_W-1:0] target_x;
      logic signed [FIELD_W-1:0] target_y;
      logic signed [FIELD_W-1:0] target_z;
      logic signed [FIELD_W-1:0] upvec_x;
      logic signed [FIELD_W-1:0] upvec_y;
      logic signed [FIELD_W-1:0] upvec_z;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] right_x;
      logic signed [FIELD_W-1:0] right_y;
      logic signed [FIELD_W-1:0] right_z;
      logic signed [FIELD_W-1:0] newup_x;
      logic signed [FIELD_W-1:0] newup_y;
      logic signed [FIELD_W-1:0] newup_z;
      logic signed [FIELD_W-1:0] look_x;
      logic signed [FIELD_W-1:0] look_y;
      logic signed [FIELD_W-1:0] look_z;
      logic signed [FIELD_W-1:0] trans_x;
      logic signed [FIELD_W-1:0] trans_y;
      logic signed [FIELD_W-1:0] trans_z;
   } rsp_type;

endpackage

### src/look_at_view_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Left-handed look-at view matrix in Q16.16: normalized look and right,
// re-orthogonalized up, and saturated translations.
// ----------------------------------------------------------------------------
//  channel | ports                       | payload  | accepted when
//  --------+-----------------------------+----------+----------------------
//  request | req_valid req_ready req_data| req_type | req_valid & req_ready
//  result  | rsp_valid rsp_ready rsp_data| rsp_type | rsp_valid & rsp_ready
//
//  One item per cycle sustained while the output is not stalled. Depth is
//  set by two normalizers in series, each a 31-stage square root plus a
//  17-stage divider.
//  The whole pipeline advances together while the output register is empty
//  or being taken; a stalled output freezes every stage, nothing is lost.
//  Synchronous active-high reset clears the valid bits only.
// ----------------------------------------------------------------------------
module look_at_view_matrix import lav_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // global advance: output slot free or being drained
   logic en;
   logic [TOT-1:0] vld_ff, vld_in;

   assign en        = !vld_ff[TOT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[TOT-1];
   assign vld_in    = {vld_ff[TOT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: difference; eye and up enter their delay lines
   logic signed [DIFF_W-1:0]  diff_ff [3];
   logic signed [FIELD_W-1:0] up_dl_ff [NL+1][3];
   logic signed [FIELD_W-1:0] eye_dl_ff [L2+4][3];

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff[0] <= DIFF_W'(req_data.target_x) - DIFF_W'(req_data.eye_x);
         diff_ff[1] <= DIFF_W'(req_data.target_y) - DIFF_W'(req_data.eye_y);
         diff_ff[2] <= DIFF_W'(req_data.target_z) - DIFF_W'(req_data.eye_z);
         up_dl_ff[0][0]  <= req_data.upvec_x;
         up_dl_ff[0][1]  <= req_data.upvec_y;
         up_dl_ff[0][2]  <= req_data.upvec_z;
         eye_dl_ff[0][0] <= req_data.eye_x;
         eye_dl_ff[0][1] <= req_data.eye_y;
         eye_dl_ff[0][2] <= req_data.eye_z;
         for (int k = 1; k < NL + 1; k++) up_dl_ff[k] <= up_dl_ff[k-1];
         for (int k = 1; k < L2 + 4; k++) eye_dl_ff[k] <= eye_dl_ff[k-1];
      end
   end

   // look = normalize(target - eye), ready at stage L1
   logic signed [UV_W-1:0] look [3];

   lav_norm u_norm_look (
      .clock (clock),
      .en    (en),
      .in_x  (NV_W'(diff_ff[0])),
      .in_y  (NV_W'(diff_ff[1])),
      .in_z  (NV_W'(diff_ff[2])),
      .out_x (look[0]),
      .out_y (look[1]),
      .out_z (look[2])
   );

   // look delay line: entry j holds stage L1+1+j
   logic signed [UV_W-1:0] look_dl_ff [NL+9][3];

   always_ff @(posedge clock) begin
      if (en) begin
         look_dl_ff[0] <= look;
         for (int k = 1; k < NL + 9; k++) look_dl_ff[k] <= look_dl_ff[k-1];
      end
   end

   // raw = up x look, exact
   logic signed [CX_W-1:0] raw [3];

   lav_cross u_cross_raw (
      .clock (clock),
      .en    (en),
      .rnd   (1'b0),
      .a_x   (up_dl_ff[NL][0]),
      .a_y   (up_dl_ff[NL][1]),
      .a_z   (up_dl_ff[NL][2]),
      .b_x   (CB_W'(look[0])),
      .b_y   (CB_W'(look[1])),
      .b_z   (CB_W'(look[2])),
      .c_x   (raw[0]),
      .c_y   (raw[1]),
      .c_z   (raw[2])
   );

   // first right = normalize(raw), ready at stage L2
   logic signed [UV_W-1:0] r0 [3];

   lav_norm u_norm_right (
      .clock (clock),
      .en    (en),
      .in_x  (raw[0]),
      .in_y  (raw[1]),
      .in_z  (raw[2]),
      .out_x (r0[0]),
      .out_y (r0[1]),
      .out_z (r0[2])
   );

   // newup = round(look x r0), ready at L2+2
   logic signed [CX_W-1:0] nup_c [3];

   lav_cross u_cross_up (
      .clock (clock),
      .en    (en),
      .rnd   (1'b1),
      .a_x   (CA_W'(look_dl_ff[NL+1][0])),
      .a_y   (CA_W'(look_dl_ff[NL+1][1])),
      .a_z   (CA_W'(look_dl_ff[NL+1][2])),
      .b_x   (CB_W'(r0[0])),
      .b_y   (CB_W'(r0[1])),
      .b_z   (CB_W'(r0[2])),
      .c_x   (nup_c[0]),
      .c_y   (nup_c[1]),
      .c_z   (nup_c[2])
   );

   logic signed [NUP_W-1:0] nup [3];
   logic signed [NUP_W-1:0] nup_dl_ff [5][3];

   always_comb begin
      for (int i = 0; i < 3; i++) nup[i] = $signed(nup_c[i][NUP_W-1:0]);
   end

   // entry j holds stage L2+3+j
   always_ff @(posedge clock) begin
      if (en) begin
         nup_dl_ff[0] <= nup;
         for (int k = 1; k < 5; k++) nup_dl_ff[k] <= nup_dl_ff[k-1];
      end
   end

   // right = round(newup x look), ready at L2+4
   logic signed [CX_W-1:0] rgt_c [3];

   lav_cross u_cross_right (
      .clock (clock),
      .en    (en),
      .rnd   (1'b1),
      .a_x   (CA_W'(nup[0])),
      .a_y   (CA_W'(nup[1])),
      .a_z   (CA_W'(nup[2])),
      .b_x   (CB_W'(look_dl_ff[NL+3][0])),
      .b_y   (CB_W'(look_dl_ff[NL+3][1])),
      .b_z   (CB_W'(look_dl_ff[NL+3][2])),
      .c_x   (rgt_c[0]),
      .c_y   (rgt_c[1]),
      .c_z   (rgt_c[2])
   );

   logic signed [RGT_W-1:0] rgt [3];
   logic signed [RGT_W-1:0] rgt_dl_ff [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) rgt[i] = $signed(rgt_c[i][RGT_W-1:0]);
   end

   // entry j holds stage L2+5+j
   always_ff @(posedge clock) begin
      if (en) begin
         rgt_dl_ff[0] <= rgt;
         for (int k = 1; k < 3; k++) rgt_dl_ff[k] <= rgt_dl_ff[k-1];
      end
   end

   // translations: products at L2+5, sums at L2+6, round/negate/sat at L2+7
   logic signed [DP_W-1:0]    dp_ff [3][3];
   logic signed [DS_W-1:0]    ds_ff [3];
   logic signed [FIELD_W-1:0] tr_ff [3], tr_in [3];
   logic signed [RGT_W-1:0]   basis [3][3];

   // all three basis vectors taken at stage L2+4
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         basis[0][i] = rgt[i];
         basis[1][i] = RGT_W'(nup_dl_ff[1][i]);
         basis[2][i] = RGT_W'(look_dl_ff[NL+5][i]);
      end
   end

   function automatic logic signed [FIELD_W-1:0] neg_round_sat(
      input logic signed [DS_W-1:0] s);
      logic signed [DS_W-1:0] r;
      logic signed [DR_W:0]   t;
      r = (s + DS_W'(1 << (FRAC_W - 1))) >>> FRAC_W;
      t = -((DR_W + 1)'(r));
      if (t > (DR_W + 1)'(33'sh0_7FFF_FFFF))
         return {1'b0, {(FIELD_W - 1){1'b1}}};
      else if (t < -(DR_W + 1)'(33'sh0_8000_0000))
         return {1'b1, {(FIELD_W - 1){1'b0}}};
      else
         return FIELD_W'(t);
   endfunction

   always_comb begin
      for (int j = 0; j < 3; j++) tr_in[j] = neg_round_sat(ds_ff[j]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++)
               dp_ff[j][i] <= eye_dl_ff[L2+3][i] * basis[j][i];
            ds_ff[j] <= DS_W'(dp_ff[j][0]) + DS_W'(dp_ff[j][1]) + DS_W'(dp_ff[j][2]);
         end
         tr_ff <= tr_in;
      end
   end

   // output register is the last entry of each line plus tr_ff
   assign rsp_data.right_x = FIELD_W'(rgt_dl_ff[2][0]);
   assign rsp_data.right_y = FIELD_W'(rgt_dl_ff[2][1]);
   assign rsp_data.right_z = FIELD_W'(rgt_dl_ff[2][2]);
   assign rsp_data.newup_x = FIELD_W'(nup_dl_ff[4][0]);
   assign rsp_data.newup_y = FIELD_W'(nup_dl_ff[4][1]);
   assign rsp_data.newup_z = FIELD_W'(nup_dl_ff[4][2]);
   assign rsp_data.look_x  = FIELD_W'(look_dl_ff[NL+8][0]);
   assign rsp_data.look_y  = FIELD_W'(look_dl_ff[NL+8][1]);
   assign rsp_data.look_z  = FIELD_W'(look_dl_ff[NL+8][2]);
   assign rsp_data.trans_x = tr_ff[0];
   assign rsp_data.trans_y = tr_ff[1];
   assign rsp_data.trans_z = tr_ff[2];

endmodule

### src/lav_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: scale, sum of squares, bit-per-stage root,
// bit-per-stage divide. Zero vector gives zero.
// ----------------------------------------------------------------------------
module lav_norm import lav_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [NV_W-1:0] in_x,
   input  logic signed [NV_W-1:0] in_y,
   input  logic signed [NV_W-1:0] in_z,
   output logic signed [UV_W-1:0] out_x,
   output logic signed [UV_W-1:0] out_y,
   output logic signed [UV_W-1:0] out_z
);

   logic signed [NV_W-1:0] vin [3];
   assign vin[0] = in_x;
   assign vin[1] = in_y;
   assign vin[2] = in_z;

   // front stages
   logic [MAG_W-1:0] mag1_ff [3], mag1_in [3];
   logic [2:0]       neg1_ff, neg1_in;
   logic [MAG_W-1:0] mag2_ff [3];
   logic [MAG_W-1:0] m2_ff, m2_in;
   logic [2:0]       neg2_ff;
   logic [MAG_W-1:0] mag3_ff [3];
   logic [TOP_W-1:0] top3_ff, top3_in;
   logic             zero3_ff;
   logic [2:0]       neg3_ff;
   logic [SM_W-1:0]  sm4_ff [3], sm4_in [3];
   logic             zero4_ff;
   logic [2:0]       neg4_ff;
   logic [SQ_W-1:0]  sq5_ff [3];
   logic [SM_W-1:0]  sm5_ff [3];
   logic             zero5_ff;
   logic [2:0]       neg5_ff;
   logic [SUM_W-1:0] sum6_ff;
   logic [SM_W-1:0]  sm6_ff [3];
   logic             zero6_ff;
   logic [2:0]       neg6_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = vin[i][NV_W-1];
         mag1_in[i] = neg1_in[i] ? MAG_W'(-vin[i]) : MAG_W'(vin[i]);
      end
      m2_in = mag1_ff[0];
      if (mag1_ff[1] > m2_in) m2_in = mag1_ff[1];
      if (mag1_ff[2] > m2_in) m2_in = mag1_ff[2];
      top3_in = '0;
      for (int j = 0; j < MAG_W; j++) begin
         if (m2_ff[j]) top3_in = TOP_W'(j);
      end
      for (int i = 0; i < 3; i++) begin
         if (top3_ff > TOP_W'(SCALE_TOP))
            sm4_in[i] = SM_W'(mag3_ff[i] >> (top3_ff - TOP_W'(SCALE_TOP)));
         else
            sm4_in[i] = SM_W'(mag3_ff[i] << (TOP_W'(SCALE_TOP) - top3_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff  <= mag1_in;
         neg1_ff  <= neg1_in;
         mag2_ff  <= mag1_ff;
         m2_ff    <= m2_in;
         neg2_ff  <= neg1_ff;
         mag3_ff  <= mag2_ff;
         top3_ff  <= top3_in;
         zero3_ff <= (m2_ff == '0);
         neg3_ff  <= neg2_ff;
         sm4_ff   <= sm4_in;
         zero4_ff <= zero3_ff;
         neg4_ff  <= neg3_ff;
         for (int i = 0; i < 3; i++) sq5_ff[i] <= SQ_W'(sm4_ff[i]) * SQ_W'(sm4_ff[i]);
         sm5_ff   <= sm4_ff;
         zero5_ff <= zero4_ff;
         neg5_ff  <= neg4_ff;
         sum6_ff  <= SUM_W'(sq5_ff[0]) + SUM_W'(sq5_ff[1]) + SUM_W'(sq5_ff[2]);
         sm6_ff   <= sm5_ff;
         zero6_ff <= zero5_ff;
         neg6_ff  <= neg5_ff;
      end
   end

   // square root, one root bit per stage, MSB first
   logic [SUM_W-1:0] rem_q_ff [RT_W], rem_q_in [RT_W], rem_src [RT_W];
   logic [RT_W-1:0]  root_q_ff [RT_W], root_q_in [RT_W], root_src [RT_W];
   logic [SM_W-1:0]  sm_q_ff [RT_W][3], sm_src [RT_W][3];
   logic             zero_q_ff [RT_W], zero_src [RT_W];
   logic [2:0]       neg_q_ff [RT_W], neg_src [RT_W];

   always_comb begin
      logic [SUM_W-1:0] trial;
      int b;
      rem_src[0]  = sum6_ff;
      root_src[0] = '0;
      sm_src[0]   = sm6_ff;
      zero_src[0] = zero6_ff;
      neg_src[0]  = neg6_ff;
      for (int k = 1; k < RT_W; k++) begin
         rem_src[k]  = rem_q_ff[k-1];
         root_src[k] = root_q_ff[k-1];
         sm_src[k]   = sm_q_ff[k-1];
         zero_src[k] = zero_q_ff[k-1];
         neg_src[k]  = neg_q_ff[k-1];
      end
      for (int k = 0; k < RT_W; k++) begin
         b = RT_W - 1 - k;
         trial = (SUM_W'(root_src[k]) << (b + 1)) | (SUM_W'(1) << (2 * b));
         if (rem_src[k] >= trial) begin
            rem_q_in[k]  = rem_src[k] - trial;
            root_q_in[k] = root_src[k] | (RT_W'(1) << b);
         end else begin
            rem_q_in[k]  = rem_src[k];
            root_q_in[k] = root_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_q_ff  <= rem_q_in;
         root_q_ff <= root_q_in;
         sm_q_ff   <= sm_src;
         zero_q_ff <= zero_src;
         neg_q_ff  <= neg_src;
      end
   end

   // dividend prep: mag * 1.0 + len / 2
   logic [NUM_W-1:0] num_ff [3];
   logic [RT_W-1:0]  len_ff;
   logic             zero_n_ff;
   logic [2:0]       neg_n_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++)
            num_ff[i] <= (NUM_W'(sm_q_ff[RT_W-1][i]) << FRAC_W)
                         + NUM_W'(root_q_ff[RT_W-1] >> 1);
         len_ff    <= root_q_ff[RT_W-1];
         zero_n_ff <= zero_q_ff[RT_W-1];
         neg_n_ff  <= neg_q_ff[RT_W-1];
      end
   end

   // restoring divide, one quotient bit per stage
   logic [NUM_W-1:0] drem_ff [Q_W][3], drem_in [Q_W][3], drem_src [Q_W][3];
   logic [Q_W-1:0]   dq_ff [Q_W][3], dq_in [Q_W][3], dq_src [Q_W][3];
   logic [RT_W-1:0]  dlen_ff [Q_W], dlen_src [Q_W];
   logic             dzero_ff [Q_W], dzero_src [Q_W];
   logic [2:0]       dneg_ff [Q_W], dneg_src [Q_W];

   always_comb begin
      logic [NUM_W-1:0] dsub;
      int b;
      drem_src[0]  = num_ff;
      dlen_src[0]  = len_ff;
      dzero_src[0] = zero_n_ff;
      dneg_src[0]  = neg_n_ff;
      for (int i = 0; i < 3; i++) dq_src[0][i] = '0;
      for (int k = 1; k < Q_W; k++) begin
         drem_src[k]  = drem_ff[k-1];
         dq_src[k]    = dq_ff[k-1];
         dlen_src[k]  = dlen_ff[k-1];
         dzero_src[k] = dzero_ff[k-1];
         dneg_src[k]  = dneg_ff[k-1];
      end
      for (int k = 0; k < Q_W; k++) begin
         b = Q_W - 1 - k;
         dsub = NUM_W'(dlen_src[k]) << b;
         for (int i = 0; i < 3; i++) begin
            if (drem_src[k][i] >= dsub) begin
               drem_in[k][i] = drem_src[k][i] - dsub;
               dq_in[k][i]   = dq_src[k][i] | (Q_W'(1) << b);
            end else begin
               drem_in[k][i] = drem_src[k][i];
               dq_in[k][i]   = dq_src[k][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         drem_ff  <= drem_in;
         dq_ff    <= dq_in;
         dlen_ff  <= dlen_src;
         dzero_ff <= dzero_src;
         dneg_ff  <= dneg_src;
      end
   end

   // sign and zero vector
   logic signed [UV_W-1:0] uo_ff [3], uo_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dzero_ff[Q_W-1])
            uo_in[i] = '0;
         else if (dneg_ff[Q_W-1][i])
            uo_in[i] = -$signed(UV_W'(dq_ff[Q_W-1][i]));
         else
            uo_in[i] = $signed(UV_W'(dq_ff[Q_W-1][i]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) uo_ff <= uo_in;
   end

   assign out_x = uo_ff[0];
   assign out_y = uo_ff[1];
   assign out_z = uo_ff[2];

endmodule

### src/lav_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_cross
// Two-stage cross product a x b, exact or rounded to Q16.16 (half up).
// ----------------------------------------------------------------------------
module lav_cross import lav_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  logic                   rnd,
   input  logic signed [CA_W-1:0] a_x,
   input  logic signed [CA_W-1:0] a_y,
   input  logic signed [CA_W-1:0] a_z,
   input  logic signed [CB_W-1:0] b_x,
   input  logic signed [CB_W-1:0] b_y,
   input  logic signed [CB_W-1:0] b_z,
   output logic signed [CX_W-1:0] c_x,
   output logic signed [CX_W-1:0] c_y,
   output logic signed [CX_W-1:0] c_z
);

   logic signed [CP_W-1:0] p_ff [6];
   logic                   rnd_ff;
   logic signed [CX_W-1:0] c_ff [3], c_in [3], d [3];

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= a_y * b_z;
         p_ff[1] <= a_z * b_y;
         p_ff[2] <= a_z * b_x;
         p_ff[3] <= a_x * b_z;
         p_ff[4] <= a_x * b_y;
         p_ff[5] <= a_y * b_x;
         rnd_ff  <= rnd;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d[i]    = CX_W'(p_ff[2*i]) - CX_W'(p_ff[2*i+1]);
         c_in[i] = rnd_ff ? ((d[i] + CX_W'(1 << (FRAC_W - 1))) >>> FRAC_W) : d[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) c_ff <= c_in;
   end

   assign c_x = c_ff[0];
   assign c_y = c_ff[1];
   assign c_z = c_ff[2];

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the look-at view matrix pipeline. A table of
// directed camera setups runs first, then random setups. Every accepted item
// is predicted in integer arithmetic or hand-typed, and every result is
// compared field by field, in order, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   import lav_pkg::*;

   localparam int NUM_RANDOM = 1300;
   localparam int LONG_HOLD  = 400;   // receiver hold-off, well past pipeline depth

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   always #6 clock = ~clock;

   look_at_view_matrix u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // directed row: setup, plus a hand-typed matrix where it is obvious
   typedef struct {
      req_type cam;
      bit      typed;
      rsp_type mat;
   } cam_row_type;

   cam_row_type camera_table[$];
   rsp_type  pending_views[$];
   int       mismatches = 0;
   int       views_checked = 0;
   int       items_sent = 0;
   int       hold_left = 0;      // set by the sender, counted down by the receiver
   bit       stim_done = 1'b0;

   localparam logic signed [31:0] MAXV = 32'sh7fffffff;
   localparam logic signed [31:0] MINV = 32'sh80000000;
   localparam logic signed [31:0] ONE  = 32'sd65536;

   // ---------------------------------------------------------------------
   // Prediction, all integer
   // ---------------------------------------------------------------------
   function automatic longint unsigned root64(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Q32.32 -> Q16.16, ties toward +inf
   function automatic longint rnd_q16(input longint v);
      longint unsigned u;
      if (v >= 0) return (v + 32768) >>> 16;
      u = longint'(-v);
      return -longint'((u + 32767) >> 16);
   endfunction

   // unit vector in Q16.16; zero stays zero
   function automatic void unit_vec(input longint v[3], output longint o[3]);
      longint unsigned mg[3];
      longint unsigned m, sum, len, q;
      int top;
      m = 0;
      sum = 0;
      top = 0;
      for (int i = 0; i < 3; i++) begin
         mg[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
         if (mg[i] > m) m = mg[i];
      end
      if (m == 0) begin
         o[0] = 0; o[1] = 0; o[2] = 0;
         return;
      end
      while (top < 63 && (m >> (top + 1)) != 0) top++;
      for (int i = 0; i < 3; i++) begin
         if (top > SCALE_TOP) mg[i] = mg[i] >> (top - SCALE_TOP);
         else                 mg[i] = mg[i] << (SCALE_TOP - top);
         sum += mg[i] * mg[i];
      end
      len = root64(sum);
      for (int i = 0; i < 3; i++) begin
         q = (mg[i] * 65536 + (len >> 1)) / len;
         o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic void cross_raw(input longint a[3], input longint b[3],
                                     output longint o[3]);
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic logic signed [31:0] neg_dot(input longint p[3], input longint d[3]);
      longint t;
      t = -rnd_q16(p[0] * d[0] + p[1] * d[1] + p[2] * d[2]);
      if (t > 64'sd2147483647)  return MAXV;
      if (t < -64'sd2147483648) return MINV;
      return t[31:0];
   endfunction

   function automatic rsp_type view_of(input req_type c);
      longint eye[3], dir[3], hint[3], look[3], raw[3], r0[3], nup[3], rgt[3];
      rsp_type m;
      eye[0] = c.eye_x; eye[1] = c.eye_y; eye[2] = c.eye_z;
      dir[0] = longint'(c.target_x) - eye[0];
      dir[1] = longint'(c.target_y) - eye[1];
      dir[2] = longint'(c.target_z) - eye[2];
      hint[0] = c.upvec_x; hint[1] = c.upvec_y; hint[2] = c.upvec_z;
      unit_vec(dir, look);
      cross_raw(hint, look, raw);
      unit_vec(raw, r0);
      cross_raw(look, r0, raw);
      for (int i = 0; i < 3; i++) nup[i] = rnd_q16(raw[i]);
      cross_raw(nup, look, raw);
      for (int i = 0; i < 3; i++) rgt[i] = rnd_q16(raw[i]);
      m.right_x = rgt[0][31:0];  m.right_y = rgt[1][31:0];  m.right_z = rgt[2][31:0];
      m.newup_x = nup[0][31:0];  m.newup_y = nup[1][31:0];  m.newup_z = nup[2][31:0];
      m.look_x  = look[0][31:0]; m.look_y  = look[1][31:0]; m.look_z  = look[2][31:0];
      m.trans_x = neg_dot(eye, rgt);
      m.trans_y = neg_dot(eye, nup);
      m.trans_z = neg_dot(eye, look);
      return m;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic req_type cam(input logic signed [31:0] ex, ey, ez,
                                   tx, ty, tz, ux, uy, uz);
      req_type c;
      c.eye_x = ex;    c.eye_y = ey;    c.eye_z = ez;
      c.target_x = tx; c.target_y = ty; c.target_z = tz;
      c.upvec_x = ux;  c.upvec_y = uy;  c.upvec_z = uz;
      return c;
   endfunction

   function automatic void add_row(input req_type c, input bit typed, input rsp_type m);
      cam_row_type r;
      r.cam = c;
      r.typed = typed;
      r.mat = m;
      camera_table.push_back(r);
   endfunction

   function automatic logic signed [31:0] rnd_field(input int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
         2: return $signed($urandom_range(0, 64)) - 32;
         default: return ($urandom_range(0, 1)) ? MAXV : MINV;
      endcase
   endfunction

   // random camera setup; most are well-formed, some hit the degenerate paths
   function automatic req_type rand_cam();
      req_type c;
      int      mode, kind;
      logic signed [31:0] k;
      mode = ($urandom_range(0, 9) < 4) ? 0 : ($urandom_range(0, 9) < 8) ? 1 :
             ($urandom_range(0, 1) ? 2 : 3);
      c = cam(rnd_field(mode), rnd_field(mode), rnd_field(mode),
              rnd_field(mode), rnd_field(mode), rnd_field(mode),
              rnd_field(mode), rnd_field(mode), rnd_field(mode));
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         // target on the eye
         c.target_x = c.eye_x; c.target_y = c.eye_y; c.target_z = c.eye_z;
      end else if (kind == 1) begin
         c.upvec_x = 0; c.upvec_y = 0; c.upvec_z = 0;
      end else if (kind == 2) begin
         // up hint parallel to the view direction, kept small so no wrap
         c.eye_x = rnd_field(1); c.eye_y = rnd_field(1); c.eye_z = rnd_field(1);
         c.target_x = rnd_field(1); c.target_y = rnd_field(1); c.target_z = rnd_field(1);
         k = $signed($urandom_range(0, 6)) - 3;
         c.upvec_x = (c.target_x - c.eye_x) * k;
         c.upvec_y = (c.target_y - c.eye_y) * k;
         c.upvec_z = (c.target_z - c.eye_z) * k;
      end else if (kind == 3) begin
         c.eye_x = rnd_field(3); c.eye_y = rnd_field(3); c.eye_z = rnd_field(3);
      end
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: drive on the rising edge, hold until taken, then push prediction
   // ---------------------------------------------------------------------
   task automatic send_item(input req_type c, input bit typed, input rsp_type m);
      int gap;
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_views.push_back(typed ? m : view_of(c));
      items_sent++;
      // idle gap: often none, usually short, now and then long
      gap = $urandom_range(0, 9);
      if (gap < 5)       gap = 0;
      else if (gap < 9)  gap = $urandom_range(1, 3);
      else               gap = $urandom_range(10, 60);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      rsp_type z, basic;
      z = '0;
      // canonical camera at the origin looking down +x with +y up
      basic = '0;
      basic.right_z = -ONE;
      basic.newup_y = ONE;
      basic.look_x  = ONE;

      add_row(cam(0, 0, 0, 0, 0, 0, 0, ONE, 0), 1, z);
      add_row(cam(MAXV, MINV, 5, MAXV, MINV, 5, 1, 2, 3), 1, z);
      add_row(cam(0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1, basic);
      add_row(cam(0, 0, 0, ONE, 0, 0, 0, 0, 0), 0, z);          // zero up hint
      add_row(cam(0, 0, 0, ONE, 0, 0, 3 * ONE, 0, 0), 0, z);    // up along look
      add_row(cam(MINV, MINV, MINV, MAXV, MAXV, MAXV, 0, ONE, 0), 0, z);
      add_row(cam(MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, 0, ONE), 0, z);
      add_row(cam(MAXV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV, MINV, MAXV), 0, z);
      add_row(cam(MINV, 0, 0, MAXV, 0, 0, MINV, MINV, 0), 0, z);
      add_row(cam(0, 0, 0, 1, 0, 0, 0, 1, 0), 0, z);            // tiny vectors
      add_row(cam(0, 0, 0, 1, 1, 1, -1, 1, -1), 0, z);
      add_row(cam(ONE, 2 * ONE, -3 * ONE, 0, 0, 0, 0, ONE, 0), 0, z);
      add_row(cam(-1, -1, -1, 0, 0, 0, MAXV, MAXV, MAXV), 0, z);
      add_row(cam(0, 0, 0, 0, 0, -ONE, 0, -ONE, 0), 0, z);
      add_row(cam(32'sh12345678, -32'sh0abcdef0, 32'sh7fff0000,
                  -32'sh00054321, 32'sh00100000, 32'sh00001000, 1, 0, 0), 0, z);
      add_row(cam(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555,
                  32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa,
                  32'sh55555555, 32'shaaaaaaaa, 32'sh55555555), 0, z);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      foreach (camera_table[i])
         send_item(camera_table[i].cam, camera_table[i].typed, camera_table[i].mat);
      for (int n = 0; n < NUM_RANDOM; n++) begin
         // halfway through, stall the output long enough to back up the pipe
         if (n == NUM_RANDOM / 2) hold_left = LONG_HOLD;
         send_item(rand_cam(), 0, z);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // ---------------------------------------------------------------------
   // Receiver: random ready, with an occasional long hold-off
   // ---------------------------------------------------------------------
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left = hold_left - 1;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            case ($urandom_range(0, 19))
               0, 1, 2, 3: stall = $urandom_range(1, 3);
               4:          stall = $urandom_range(15, 80);
               default:    stall = 0;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checker: in-order compare of the twelve fields
   // ---------------------------------------------------------------------
   string field_name[12] = '{"right_x", "right_y", "right_z", "newup_x", "newup_y",
                             "newup_z", "look_x", "look_y", "look_z",
                             "trans_x", "trans_y", "trans_z"};

   always @(posedge clock) begin
      rsp_type want;
      logic [31:0] w, g;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_views.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result %h", rsp_data);
         end else begin
            want = pending_views.pop_front();
            views_checked++;
            for (int i = 0; i < 12; i++) begin
               w = want[383 - 32 * i -: 32];
               g = rsp_data[383 - 32 * i -: 32];
               if (w !== g) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: result %0d %s expected %h got %h",
                              views_checked, field_name[i], w, g);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // End of run
   // ---------------------------------------------------------------------
   initial begin
      wait (stim_done);
      while (pending_views.size() != 0) @(posedge clock);
      repeat (TOT + 20) @(posedge clock);
      $display("Ran %0d camera setups (%0d directed), %0d matrices checked, %0d mismatches.",
               items_sent, camera_table.size(), views_checked, mismatches);
      $display("Covered degenerate look and up, extreme coordinates, saturation, stalls.");
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("ERROR: timeout with %0d results outstanding", pending_views.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
